// ----- design/assert_macros.svh -----
// Assertion macros used by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMP(label, clk, rstn, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while reset is low.
`define ASSERT_NXT(label, clk, rstn, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// ----- design/wfba_pkg.sv -----
// Types and constants of the worst-fit block allocator.
`default_nettype none
package wfba_pkg;
  localparam int unsigned POOL_BLOCKS = 1024;
  localparam int unsigned BLOCK_BYTES = 16;
  localparam int unsigned IDX_W  = $clog2(POOL_BLOCKS);
  localparam int unsigned PTR_W  = IDX_W + 1;
  localparam int unsigned FREE_W = 10;
  localparam int unsigned REQ_W  = 14;
  localparam int unsigned HDL_W  = 10;
  localparam int unsigned STAT_W = 3;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_NO_SPACE  = 3'd1;
  localparam logic [STAT_W-1:0] ST_ZERO_SIZE = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_IGNORED   = 3'd4;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    logic [PTR_W-1:0]  next;
    logic [FREE_W-1:0] free;
  } header_t;
endpackage
`default_nettype wire

// ----- design/worst_fit_block_allocator.sv -----
// Worst-fit block allocator with coalescing: sequencer over one header RAM.
// Usage:
//   Input channel s_axis: tuser carries the command (0 allocate, 1 free),
//   tdata carries request_bytes and release_handle. Output channel m_axis:
//   tdata carries granted_handle and status. Every item gives one result.
//   The block takes one item at a time. An allocate walks the whole header
//   chain with one RAM read and one compare per header, then writes one or
//   two headers, or none if no region fits; a free walks the chain up to the
//   matching header the same way, reads the next header if one follows
//   and writes one or two headers. The single header RAM port pair sets the
//   pace of the walks.
//   Zero-size and ignored requests go straight to the result.
//   The heap is built lazily on the first non-empty allocate (two writes).
//   Reset clears the heap-ready flag and all control; the RAM keeps garbage
//   that is never read before it is written, so no clearing pass is needed.
//   A finished result sits in an output register; a new item is taken while
//   it waits. If the receiver stalls, the next finished result holds in the
//   sequencer until the output register empties.
`default_nettype none
`include "assert_macros.svh"
module worst_fit_block_allocator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,  // [13:0] request_bytes, [23:14] release_handle
  input  wire logic        s_axis_tuser_i,  // [0] command
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [15:0] m_axis_tdata_o   // [9:0] granted_handle, [12:10] status, pad
);
  localparam int unsigned IW = wfba_pkg::IDX_W;
  localparam int unsigned PW = wfba_pkg::PTR_W;
  localparam int unsigned FW = wfba_pkg::FREE_W;
  localparam int unsigned RW = wfba_pkg::REQ_W;
  localparam int unsigned HW = wfba_pkg::HDL_W;
  localparam int unsigned SW = wfba_pkg::STAT_W;
  localparam logic [PW-1:0] POOL = PW'(wfba_pkg::POOL_BLOCKS);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_INIT0  = 4'd1;
  localparam logic [3:0] S_INIT1  = 4'd2;
  localparam logic [3:0] S_ARD    = 4'd3;
  localparam logic [3:0] S_AEV    = 4'd4;
  localparam logic [3:0] S_ADEC   = 4'd5;
  localparam logic [3:0] S_ASPLIT = 4'd6;
  localparam logic [3:0] S_ABEST  = 4'd7;
  localparam logic [3:0] S_FRD    = 4'd8;
  localparam logic [3:0] S_FEV    = 4'd9;
  localparam logic [3:0] S_FNB    = 4'd10;
  localparam logic [3:0] S_FWCUR  = 4'd11;
  localparam logic [3:0] S_FWPREV = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  logic [3:0]    state_q, state_d;
  logic          ready_q, ready_d;
  logic [PW-1:0] cur_q, cur_d, prev_q, prev_d, steps_q, steps_d;
  logic [IW-1:0] best_q, best_d;
  logic [PW-1:0] bnext_q, bnext_d, ncur_q, ncur_d;
  logic [FW-1:0] largest_q, largest_d, fcur_q, fcur_d, pfree_q, pfree_d;
  logic          found_q, found_d;
  logic [RW-1:0] need_q, need_d;
  logic [HW-1:0] hdl_q, hdl_d;
  logic [HW-1:0] rh_q, rh_d;
  logic [SW-1:0] rs_q, rs_d;
  logic          ov_q, ov_d;
  logic [HW-1:0] oh_q, oh_d;
  logic [SW-1:0] os_q, os_d;

  logic                we;
  logic [IW-1:0]       waddr, raddr;
  wfba_pkg::header_t   wdata, rdata;

  logic              in_acc;
  logic [RW-1:0]     in_bytes;
  logic [HW-1:0]     in_hdl;
  logic [RW+12:0]    need_sum;
  logic [RW+1:0]     split;
  logic [PW-1:0]     end_c, span_c, end_n;
  logic [PW:0]       nb_plus1;

  wfba_ram #(
    .WIDTH($bits(wfba_pkg::header_t)),
    .DEPTH(wfba_pkg::POOL_BLOCKS)
  ) u_hdr_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign in_bytes = s_axis_tdata_i[RW-1:0];
  assign in_hdl   = s_axis_tdata_i[RW+HW-1:RW];
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = {3'b000, os_q, oh_q};

  // Round bytes up to whole blocks.
  assign need_sum = (RW+13)'(in_bytes) + (RW+13)'(wfba_pkg::BLOCK_BYTES - 1);
  assign split    = (RW+2)'(best_q) + (RW+2)'(need_q) + (RW+2)'(1);
  // Span of the current header, from the next pointer just read.
  assign end_c    = (rdata.next < POOL) ? rdata.next : POOL;
  assign span_c   = (end_c > cur_q) ? (end_c - cur_q) : PW'(1);
  assign end_n    = (rdata.next < POOL) ? rdata.next : POOL;
  assign nb_plus1 = {1'b0, ncur_q} + (PW+1)'(1);

  always_comb begin
    state_d = state_q;  ready_d = ready_q;
    cur_d = cur_q;  prev_d = prev_q;  steps_d = steps_q;
    best_d = best_q;  bnext_d = bnext_q;  ncur_d = ncur_q;
    largest_d = largest_q;  fcur_d = fcur_q;  pfree_d = pfree_q;
    found_d = found_q;  need_d = need_q;  hdl_d = hdl_q;
    rh_d = rh_q;  rs_d = rs_q;
    ov_d = ov_q;  oh_d = oh_q;  os_d = os_q;
    we = 1'b0;  waddr = '0;  wdata = '0;  raddr = cur_q[IW-1:0];

    if (ov_q && m_axis_tready_i) begin
      ov_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cur_d = '0;  prev_d = '0;  steps_d = '0;
          largest_d = '0;  found_d = 1'b0;  best_d = '0;  pfree_d = '0;
          need_d = RW'(need_sum / wfba_pkg::BLOCK_BYTES);
          hdl_d = in_hdl;
          rh_d = '0;
          if (s_axis_tuser_i == wfba_pkg::CMD_ALLOC) begin
            if (in_bytes == '0) begin
              rs_d = wfba_pkg::ST_ZERO_SIZE;
              state_d = S_DONE;
            end else if (!ready_q) begin
              state_d = S_INIT0;
            end else begin
              state_d = S_ARD;
            end
          end else begin
            if (in_hdl == '0 || !ready_q) begin
              rs_d = wfba_pkg::ST_IGNORED;
              state_d = S_DONE;
            end else begin
              state_d = S_FRD;
            end
          end
        end
      end
      // Lay down the anchor, then one region holding the rest of the pool.
      S_INIT0: begin
        we = 1'b1;  waddr = '0;
        wdata.next = PW'(1);  wdata.free = '0;
        state_d = S_INIT1;
      end
      S_INIT1: begin
        we = 1'b1;  waddr = IW'(1);
        wdata.next = POOL;  wdata.free = FW'(wfba_pkg::POOL_BLOCKS - 2);
        ready_d = 1'b1;
        state_d = S_ARD;
      end
      S_ARD: begin
        if (steps_q < POOL && cur_q < POOL) begin
          state_d = S_AEV;
        end else begin
          state_d = S_ADEC;
        end
      end
      S_AEV: begin
        if (rdata.free > largest_q) begin
          largest_d = rdata.free;
          best_d = cur_q[IW-1:0];
          bnext_d = rdata.next;
          found_d = 1'b1;
        end
        cur_d = rdata.next;
        steps_d = steps_q + PW'(1);
        state_d = S_ARD;
      end
      S_ADEC: begin
        if (!found_q || RW'(largest_q) < need_q) begin
          rs_d = wfba_pkg::ST_NO_SPACE;
          state_d = S_DONE;
        end else if (RW'(largest_q) > need_q && split < (RW+2)'(POOL)) begin
          state_d = S_ASPLIT;
        end else begin
          state_d = S_ABEST;
        end
      end
      S_ASPLIT: begin
        we = 1'b1;  waddr = split[IW-1:0];
        wdata.next = bnext_q;
        wdata.free = FW'(RW'(largest_q) - need_q - RW'(1));
        bnext_d = PW'(split);
        state_d = S_ABEST;
      end
      S_ABEST: begin
        we = 1'b1;  waddr = best_q;
        wdata.next = bnext_q;  wdata.free = '0;
        rh_d = HW'(best_q + IW'(1));
        rs_d = wfba_pkg::ST_OK;
        state_d = S_DONE;
      end
      S_FRD: begin
        if (steps_q < POOL && cur_q < POOL) begin
          state_d = S_FEV;
        end else begin
          rs_d = wfba_pkg::ST_NOT_FOUND;
          state_d = S_DONE;
        end
      end
      S_FEV: begin
        if (HW'(cur_q + PW'(1)) == hdl_q) begin
          fcur_d = FW'(span_c - PW'(1));
          ncur_d = rdata.next;
          if (rdata.next < POOL && rdata.next > cur_q) begin
            raddr = rdata.next[IW-1:0];
            state_d = S_FNB;
          end else begin
            state_d = S_FWCUR;
          end
        end else begin
          prev_d = cur_q;
          pfree_d = rdata.free;
          cur_d = rdata.next;
          steps_d = steps_q + PW'(1);
          state_d = S_FRD;
        end
      end
      // Absorb a free next region, or an empty one a single block long.
      S_FNB: begin
        if (rdata.free != '0) begin
          fcur_d = fcur_q + rdata.free + FW'(1);
          ncur_d = rdata.next;
        end else if ({1'b0, end_n} <= nb_plus1) begin
          fcur_d = fcur_q + FW'(1);
          ncur_d = rdata.next;
        end
        state_d = S_FWCUR;
      end
      S_FWCUR: begin
        we = 1'b1;  waddr = cur_q[IW-1:0];
        wdata.next = ncur_q;  wdata.free = fcur_q;
        rs_d = wfba_pkg::ST_OK;
        if (cur_q != '0 && prev_q != cur_q && pfree_q != '0) begin
          state_d = S_FWPREV;
        end else begin
          state_d = S_DONE;
        end
      end
      S_FWPREV: begin
        we = 1'b1;  waddr = prev_q[IW-1:0];
        wdata.next = ncur_q;  wdata.free = pfree_q + fcur_q + FW'(1);
        state_d = S_DONE;
      end
      S_DONE: begin
        // Hold until the output register is free.
        if (!ov_q || m_axis_tready_i) begin
          ov_d = 1'b1;  oh_d = rh_q;  os_d = rs_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;  prev_q <= prev_d;  steps_q <= steps_d;
    best_q <= best_d;  bnext_q <= bnext_d;  ncur_q <= ncur_d;
    largest_q <= largest_d;  fcur_q <= fcur_d;  pfree_q <= pfree_d;
    found_q <= found_d;  need_q <= need_d;  hdl_q <= hdl_d;
    rh_q <= rh_d;  rs_q <= rs_d;  oh_q <= oh_d;  os_q <= os_d;
  end

  `ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_acc, !s_axis_tready_o)
  `ASSERT_IMP(a_handle_only_ok, clk_i, rst_ni, ov_q && oh_q != '0, os_q == wfba_pkg::ST_OK)
  `ASSERT_IMP(a_walk_bounded, clk_i, rst_ni, state_q == S_AEV || state_q == S_FEV,
              steps_q < POOL && cur_q < POOL)
endmodule
`default_nettype wire

// ----- design/wfba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wfba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire
